/* hdl/rv32id_pkg.sv */
// Shared definitions for the RV32I instruction decoder.
// Holds opcode and format codes and the decoded result type; depends on nothing.
package rv32id_pkg;

    localparam logic [6:0] MAJ_LOAD   = 7'h03;
    localparam logic [6:0] MAJ_IMM    = 7'h13;
    localparam logic [6:0] MAJ_AUIPC  = 7'h17;
    localparam logic [6:0] MAJ_STORE  = 7'h23;
    localparam logic [6:0] MAJ_OP     = 7'h33;
    localparam logic [6:0] MAJ_LUI    = 7'h37;
    localparam logic [6:0] MAJ_BRANCH = 7'h63;
    localparam logic [6:0] MAJ_JALR   = 7'h67;
    localparam logic [6:0] MAJ_JAL    = 7'h6F;

    localparam logic [2:0] FMT_I = 3'd0;
    localparam logic [2:0] FMT_U = 3'd1;
    localparam logic [2:0] FMT_R = 3'd2;
    localparam logic [2:0] FMT_J = 3'd3;
    localparam logic [2:0] FMT_B = 3'd4;
    localparam logic [2:0] FMT_S = 3'd5;

    localparam logic [1:0] STN_LOAD  = 2'd0;
    localparam logic [1:0] STN_STORE = 2'd1;
    localparam logic [1:0] STN_RS    = 2'd2;

    localparam logic [1:0] RBK_STORE  = 2'd0;
    localparam logic [1:0] RBK_BRANCH = 2'd1;
    localparam logic [1:0] RBK_JALR   = 2'd2;
    localparam logic [1:0] RBK_REG    = 2'd3;

    localparam logic [2:0] F3_SLTIU = 3'd3;

    localparam int INSTR_W = 32;
    localparam int RESULT_W = 80;

    typedef struct packed {
        logic [4:0]  alu_code;
        logic [1:0]  rob_kind;
        logic [1:0]  station_kind;
        logic [10:0] packed_op;
        logic [2:0]  format_kind;
        logic [6:0]  major_opcode;
        logic [31:0] imm_value;
        logic [2:0]  funct3_field;
        logic [4:0]  src2_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  dest_reg;
    } dec_result_t;

endpackage

/* hdl/rv32i_instruction_decoder.sv */
// RV32I instruction decoder: one instruction word in, one decoded result out.
// Instruction register, then result register, with a single decode pass between them;
// one transaction per cycle while m_axis_tready does not stall the output.
// Either register stage accepts a new transaction while its contents move on.
// rst_n asynchronously clears both valid flags; data registers are not reset.
// Uses rv32id_pkg for opcode codes and the result type.
module rv32i_instruction_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] instruction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] dest_reg, [9:5] src1_reg, [14:10] src2_reg, [17:15] funct3_field,
    // [49:18] imm_value, [56:50] major_opcode, [59:57] format_kind,
    // [70:60] packed_op, [72:71] station_kind, [74:73] rob_kind, [79:75] alu_code
    output logic [rv32id_pkg::RESULT_W-1:0] m_axis_tdata,
    output logic        m_axis_tuser    // [0] illegal
);

    logic                                in_valid_reg;
    logic [rv32id_pkg::INSTR_W-1:0]      instr_reg;
    logic                                out_valid_reg;
    rv32id_pkg::dec_result_t             result_reg;
    rv32id_pkg::dec_result_t             result_next;
    logic                                illegal_reg;
    logic                                illegal_next;
    logic                                out_ready;
    logic                                in_ready;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    logic [10:0] pop;
    logic [31:0] imm;
    logic [2:0]  fmt;
    logic        known;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign in_ready      = !in_valid_reg || out_ready;
    assign s_axis_tready = in_ready;

    assign opc   = instr_reg[6:0];
    assign f3    = instr_reg[14:12];
    assign imm_i = {{20{instr_reg[31]}}, instr_reg[31:20]};

    always_comb
    begin
        known = 1'b1;
        fmt   = rv32id_pkg::FMT_I;
        pop   = 11'd0;
        imm   = imm_i;
        case (opc)
            rv32id_pkg::MAJ_IMM, rv32id_pkg::MAJ_LOAD, rv32id_pkg::MAJ_JALR:
            begin
                fmt = rv32id_pkg::FMT_I;
                pop = {1'b0, f3, opc};
                // SLTIU takes its immediate zero-extended.
                if (opc == rv32id_pkg::MAJ_IMM && f3 == rv32id_pkg::F3_SLTIU)
                begin
                    imm = {20'd0, instr_reg[31:20]};
                end
            end
            rv32id_pkg::MAJ_LUI, rv32id_pkg::MAJ_AUIPC:
            begin
                fmt = rv32id_pkg::FMT_U;
                pop = {4'd0, opc};
                imm = {instr_reg[31:12], 12'd0};
            end
            rv32id_pkg::MAJ_OP:
            begin
                fmt = rv32id_pkg::FMT_R;
                pop = {instr_reg[30], f3, opc};
            end
            rv32id_pkg::MAJ_JAL:
            begin
                fmt = rv32id_pkg::FMT_J;
                pop = {4'd0, opc};
                imm = {{12{instr_reg[31]}}, instr_reg[19:12], instr_reg[20],
                       instr_reg[30:21], 1'b0};
            end
            rv32id_pkg::MAJ_BRANCH:
            begin
                fmt = rv32id_pkg::FMT_B;
                pop = {1'b0, f3, opc};
                imm = {{20{instr_reg[31]}}, instr_reg[7], instr_reg[30:25],
                       instr_reg[11:8], 1'b0};
            end
            rv32id_pkg::MAJ_STORE:
            begin
                fmt = rv32id_pkg::FMT_S;
                pop = {1'b0, f3, opc};
                imm = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result_next              = '0;
        illegal_next             = !known;
        if (known)
        begin
            result_next.dest_reg     = instr_reg[11:7];
            result_next.src1_reg     = instr_reg[19:15];
            result_next.src2_reg     = instr_reg[24:20];
            result_next.funct3_field = f3;
            result_next.imm_value    = imm;
            result_next.major_opcode = opc;
            result_next.format_kind  = fmt;
            result_next.packed_op    = pop;
            if (opc == rv32id_pkg::MAJ_LOAD)
                result_next.station_kind = rv32id_pkg::STN_LOAD;
            else if (opc == rv32id_pkg::MAJ_STORE)
                result_next.station_kind = rv32id_pkg::STN_STORE;
            else
                result_next.station_kind = rv32id_pkg::STN_RS;
            if (opc == rv32id_pkg::MAJ_STORE)
                result_next.rob_kind = rv32id_pkg::RBK_STORE;
            else if (opc == rv32id_pkg::MAJ_JAL || opc == rv32id_pkg::MAJ_BRANCH)
                result_next.rob_kind = rv32id_pkg::RBK_BRANCH;
            else if (opc == rv32id_pkg::MAJ_JALR)
                result_next.rob_kind = rv32id_pkg::RBK_JALR;
            else
                result_next.rob_kind = rv32id_pkg::RBK_REG;
            // The top bit of the ALU code marks a conditional branch.
            result_next.alu_code = {(opc == rv32id_pkg::MAJ_BRANCH), pop[10:7]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= s_axis_tvalid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
            instr_reg <= s_axis_tdata;
        if (out_ready && in_valid_reg)
        begin
            result_reg  <= result_next;
            illegal_reg <= illegal_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;
    assign m_axis_tuser  = illegal_reg;

endmodule

/* bench/rv32i_instruction_decoder_tb.sv */
// Self-checking testbench for the RV32I instruction decoder stream block.
// Drives instruction words, predicts each decoded result and compares it field by field.
// Depends on rv32id_pkg and rv32i_instruction_decoder.
module rv32i_instruction_decoder_tb;

    typedef struct packed {
        logic                    illegal;
        rv32id_pkg::dec_result_t fields;
    } decoded_t;

    typedef struct packed {
        logic        drain_first;
        logic [31:0] word;
    } instr_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;

    instr_item_t pending_words[$];
    decoded_t    expected_decodes[$];

    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned illegal_words = 0;
    int unsigned mismatches = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned sender_gap = 0;
    int unsigned receiver_gap = 0;
    int unsigned holdoff_left = 0;
    logic        holdoff_done = 1'b0;
    logic        idle_ok = 1'b1;

    rv32i_instruction_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end

    // Works out the decoded fields of one instruction word.
    function automatic decoded_t decode_word(input logic [31:0] w);
        decoded_t    d;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [11:0] imm12;
        logic [10:0] op_f3;
        logic [10:0] pop;
        logic [2:0]  fmt;
        logic [31:0] imm;
        logic        bad;
        opc = w[6:0];
        f3 = w[14:12];
        imm12 = w[31:20];
        op_f3 = {1'b0, f3, opc};
        imm = {{20{imm12[11]}}, imm12};
        pop = '0;
        fmt = rv32id_pkg::FMT_I;
        bad = 1'b0;
        case (opc)
            rv32id_pkg::MAJ_IMM, rv32id_pkg::MAJ_LOAD, rv32id_pkg::MAJ_JALR:
            begin
                fmt = rv32id_pkg::FMT_I;
                pop = op_f3;
                // SLTIU compares against an unsigned immediate.
                if (opc == rv32id_pkg::MAJ_IMM && f3 == rv32id_pkg::F3_SLTIU)
                    imm = {20'b0, imm12};
            end
            rv32id_pkg::MAJ_LUI, rv32id_pkg::MAJ_AUIPC:
            begin
                fmt = rv32id_pkg::FMT_U;
                pop = {4'b0, opc};
                imm = {w[31:12], 12'b0};
            end
            rv32id_pkg::MAJ_OP:
            begin
                fmt = rv32id_pkg::FMT_R;
                pop = {w[30], f3, opc};
            end
            rv32id_pkg::MAJ_JAL:
            begin
                fmt = rv32id_pkg::FMT_J;
                pop = {4'b0, opc};
                imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            end
            rv32id_pkg::MAJ_BRANCH:
            begin
                fmt = rv32id_pkg::FMT_B;
                pop = op_f3;
                imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
            end
            rv32id_pkg::MAJ_STORE:
            begin
                fmt = rv32id_pkg::FMT_S;
                pop = op_f3;
                imm = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            default:
                bad = 1'b1;
        endcase
        d = '0;
        if (bad)
        begin
            d.illegal = 1'b1;
            return d;
        end
        d.fields.dest_reg = w[11:7];
        d.fields.src1_reg = w[19:15];
        d.fields.src2_reg = w[24:20];
        d.fields.funct3_field = f3;
        d.fields.imm_value = imm;
        d.fields.major_opcode = opc;
        d.fields.format_kind = fmt;
        d.fields.packed_op = pop;
        d.fields.station_kind = (opc == rv32id_pkg::MAJ_LOAD) ? rv32id_pkg::STN_LOAD :
                                (opc == rv32id_pkg::MAJ_STORE) ? rv32id_pkg::STN_STORE :
                                rv32id_pkg::STN_RS;
        if (opc == rv32id_pkg::MAJ_STORE)
            d.fields.rob_kind = rv32id_pkg::RBK_STORE;
        else if (opc == rv32id_pkg::MAJ_JAL || opc == rv32id_pkg::MAJ_BRANCH)
            d.fields.rob_kind = rv32id_pkg::RBK_BRANCH;
        else if (opc == rv32id_pkg::MAJ_JALR)
            d.fields.rob_kind = rv32id_pkg::RBK_JALR;
        else
            d.fields.rob_kind = rv32id_pkg::RBK_REG;
        d.fields.alu_code = {1'b0, pop[10:7]} |
                            ((opc == rv32id_pkg::MAJ_BRANCH) ? 5'h10 : 5'h00);
        return d;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_word(input logic [31:0] w, input logic drain);
        instr_item_t item;
        item.word = w;
        item.drain_first = drain;
        pending_words.push_back(item);
    endtask

    // Sender: offers queued words, with random gaps and drain pauses.
    always @(posedge clk or negedge rst_n)
    begin
        instr_item_t item;
        logic        sent;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            sender_gap <= 0;
            idle_ok <= 1'b1;
        end
        else
        begin
            sent = s_axis_tvalid && s_axis_tready;
            if (sent)
            begin
                expected_decodes.push_back(decode_word(s_axis_tdata));
                words_sent++;
            end
            else if (s_axis_tvalid)
                input_stall_cycles++;
            // Idling comes in stretches; the tail of the run has none.
            idle_ok <= (pending_words.size() > 150) && ((words_sent % 384) < 256);
            if (!s_axis_tvalid || sent)
            begin
                if (sender_gap != 0)
                begin
                    sender_gap <= sender_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain_first && expected_decodes.size() != 0))
                begin
                    item = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= item.word;
                    if (idle_ok && holdoff_left == 0 && $urandom_range(0, 7) == 0)
                        sender_gap <= $urandom_range(1, 19);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so that both register stages fill and the input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (!holdoff_done && results_checked >= 500)
        begin
            holdoff_left <= 80;
            holdoff_done <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Receiver: checks each result transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t                want;
        rv32id_pkg::dec_result_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            receiver_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_decodes.size() == 0)
                begin
                    $error("result transaction with no pending instruction word");
                    mismatches++;
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    results_checked++;
                    if (want.illegal)
                        illegal_words++;
                    compare_field("illegal", 32'(want.illegal), 32'(m_axis_tuser));
                    compare_field("dest_reg", 32'(want.fields.dest_reg),
                                  32'(got.dest_reg));
                    compare_field("src1_reg", 32'(want.fields.src1_reg),
                                  32'(got.src1_reg));
                    compare_field("src2_reg", 32'(want.fields.src2_reg),
                                  32'(got.src2_reg));
                    compare_field("funct3_field", 32'(want.fields.funct3_field),
                                  32'(got.funct3_field));
                    compare_field("imm_value", want.fields.imm_value, got.imm_value);
                    compare_field("major_opcode", 32'(want.fields.major_opcode),
                                  32'(got.major_opcode));
                    compare_field("format_kind", 32'(want.fields.format_kind),
                                  32'(got.format_kind));
                    compare_field("packed_op", 32'(want.fields.packed_op),
                                  32'(got.packed_op));
                    compare_field("station_kind", 32'(want.fields.station_kind),
                                  32'(got.station_kind));
                    compare_field("rob_kind", 32'(want.fields.rob_kind),
                                  32'(got.rob_kind));
                    compare_field("alu_code", 32'(want.fields.alu_code),
                                  32'(got.alu_code));
                end
            end
            if (holdoff_left != 0)
                m_axis_tready <= 1'b0;
            else if (receiver_gap != 0)
            begin
                receiver_gap <= receiver_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 9) == 0)
            begin
                receiver_gap <= $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [31:0] w;
        logic [6:0]  opc;

        // Field extremes, every format and the decoding corner cases.
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word({20'hFFFFF, 5'd31, rv32id_pkg::MAJ_LUI}, 1'b0);
        queue_word({20'h00000, 5'd0, rv32id_pkg::MAJ_AUIPC}, 1'b0);
        queue_word({20'h80001, 5'd17, rv32id_pkg::MAJ_AUIPC}, 1'b0);
        queue_word({25'h1FF_FFFF, rv32id_pkg::MAJ_JAL}, 1'b0);
        queue_word({25'h0AA_AAAA, rv32id_pkg::MAJ_JAL}, 1'b0);
        queue_word({25'h1FF_FFFF, rv32id_pkg::MAJ_BRANCH}, 1'b0);
        queue_word({1'b0, 6'h15, 5'd7, 5'd8, 3'd1, 4'hA, 1'b1, rv32id_pkg::MAJ_BRANCH},
                   1'b0);
        queue_word({25'h1FF_FFFF, rv32id_pkg::MAJ_STORE}, 1'b0);
        queue_word({7'h00, 5'd1, 5'd2, 3'd2, 5'd31, rv32id_pkg::MAJ_STORE}, 1'b0);
        queue_word({12'h800, 5'd3, 3'd2, 5'd4, rv32id_pkg::MAJ_LOAD}, 1'b0);
        queue_word({12'h7FF, 5'd31, 3'd4, 5'd0, rv32id_pkg::MAJ_LOAD}, 1'b0);
        queue_word({12'hFFF, 5'd1, 3'd0, 5'd1, rv32id_pkg::MAJ_JALR}, 1'b0);
        queue_word({12'hFFF, 5'd2, rv32id_pkg::F3_SLTIU, 5'd3, rv32id_pkg::MAJ_IMM}, 1'b0);
        queue_word({12'hFFF, 5'd2, 3'd2, 5'd3, rv32id_pkg::MAJ_IMM}, 1'b0);
        queue_word({7'b0100000, 5'd31, 5'd5, 3'd5, 5'd6, rv32id_pkg::MAJ_IMM}, 1'b0);
        queue_word({7'b0000000, 5'd1, 5'd5, 3'd5, 5'd6, rv32id_pkg::MAJ_IMM}, 1'b0);
        queue_word({7'b0000000, 5'd7, 5'd5, 3'd1, 5'd6, rv32id_pkg::MAJ_IMM}, 1'b0);
        queue_word({7'b0000000, 5'd2, 5'd1, 3'd0, 5'd3, rv32id_pkg::MAJ_OP}, 1'b0);
        queue_word({7'b0100000, 5'd2, 5'd1, 3'd0, 5'd3, rv32id_pkg::MAJ_OP}, 1'b0);
        queue_word({7'b0100000, 5'd2, 5'd1, 3'd5, 5'd3, rv32id_pkg::MAJ_OP}, 1'b0);
        queue_word({25'h1FF_FFFF, rv32id_pkg::MAJ_OP}, 1'b0);
        queue_word({25'h1AB_CDEF, 7'h73}, 1'b0);
        queue_word({25'h000_0000, 7'h0F}, 1'b0);

        // Mostly supported opcodes with random upper bits, some raw random words.
        for (int i = 0; i < 1750; i++)
        begin
            w = $urandom();
            case ($urandom_range(0, 8))
                0: opc = rv32id_pkg::MAJ_LOAD;
                1: opc = rv32id_pkg::MAJ_IMM;
                2: opc = rv32id_pkg::MAJ_AUIPC;
                3: opc = rv32id_pkg::MAJ_STORE;
                4: opc = rv32id_pkg::MAJ_OP;
                5: opc = rv32id_pkg::MAJ_LUI;
                6: opc = rv32id_pkg::MAJ_BRANCH;
                7: opc = rv32id_pkg::MAJ_JALR;
                default: opc = rv32id_pkg::MAJ_JAL;
            endcase
            if ($urandom_range(0, 9) != 0)
                w[6:0] = opc;
            queue_word(w, (i == 0) || (i == 700) || (i == 1300));
        end

        while (pending_words.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_decodes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Decoded %0d instruction words, %0d of them unsupported; %0d results checked.",
                 words_sent, illegal_words, results_checked);
        $display("Input was stalled for %0d cycles; %0d field mismatches found.",
                 input_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
